@@ rtl/stat_pkg.sv @@
`default_nettype none

package stat_pkg;

	// table geometry
	localparam int SECTION_SLOTS = 16;
	localparam int SLOT_W  = (SECTION_SLOTS > 1) ? $clog2(SECTION_SLOTS) : 1;
	localparam int LIMIT_W = $clog2(SECTION_SLOTS + 1);

	// field widths
	localparam int ADDR_W  = 32;
	localparam int COUNT_W = 5;
	localparam int ENTRY_W = 4;
	localparam int HIT_W   = 5;

	// miss result values
	localparam logic [HIT_W-1:0]  MISS_INDEX  = '1;
	localparam logic [ADDR_W-1:0] MISS_OFFSET = '1;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	// one section descriptor as stored in the table
	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] span;
		logic [ADDR_W-1:0] file_pos;
	} sect_entry_t;

	// result of the range check
	typedef struct packed {
		logic              hit;
		logic [ADDR_W-1:0] delta;
	} range_res_t;

endpackage

`default_nettype wire

@@ rtl/section_table_address_translator.sv @@
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+---------------------------------------------
// input    | in        | in_valid / in_ready    | op, entry_index, entry_base, entry_span,
//          |           |                        | entry_file_pos, rva
// result   | out       | out_valid / out_ready  | found, hit_index, file_offset
// config   | in        | cfg_valid / cfg_ready  | cfg_data (section_count)
//
// a write request loads the result register in the emit state, a lookup after n scan steps,
// n = entries checked (0 to min(section_count, 16), stops at the first hit), one a cycle.
// in_ready is high only while idle, so a new request waits until the last one leaves emit; a
// finished result waits in the output register while the next request runs, and a second
// one holds the sequencer until the first is taken. cfg_ready is always high.
// arst_n clears the sequencer, the result valid and section_count; the table needs none.
`default_nettype none

module section_table_address_translator (
	input  wire                                  clk,
	input  wire                                  arst_n,

	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [stat_pkg::COUNT_W-1:0]    cfg_data,

	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire logic                            op,
	input  wire logic [stat_pkg::ENTRY_W-1:0]    entry_index,
	input  wire logic [stat_pkg::ADDR_W-1:0]     entry_base,
	input  wire logic [stat_pkg::ADDR_W-1:0]     entry_span,
	input  wire logic [stat_pkg::ADDR_W-1:0]     entry_file_pos,
	input  wire logic [stat_pkg::ADDR_W-1:0]     rva,

	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic                                 found,
	output logic [stat_pkg::HIT_W-1:0]           hit_index,
	output logic [stat_pkg::ADDR_W-1:0]          file_offset
);

	stat_pkg::state_t state_q, state_d;

	logic [stat_pkg::COUNT_W-1:0] count_q;
	logic [stat_pkg::SLOT_W-1:0]  idx_q;
	logic [stat_pkg::LIMIT_W-1:0] limit_q;
	logic [stat_pkg::LIMIT_W-1:0] limit_next;
	logic [stat_pkg::ADDR_W-1:0]  rva_q;
	logic                         res_hit_q;
	logic [stat_pkg::SLOT_W-1:0]  res_idx_q;
	logic [stat_pkg::ADDR_W-1:0]  res_delta_q;
	logic [stat_pkg::ADDR_W-1:0]  res_pos_q;

	logic                         out_valid_q;
	logic                         found_q;
	logic [stat_pkg::HIT_W-1:0]   hit_index_q;
	logic [stat_pkg::ADDR_W-1:0]  file_offset_q;

	logic                         in_acc;
	logic                         is_lookup;
	logic                         wr_en;
	logic [stat_pkg::SLOT_W-1:0]  rd_addr;
	logic                         last_entry;
	logic                         out_load;

	stat_pkg::sect_entry_t        wr_entry;
	stat_pkg::sect_entry_t        rd_entry;
	stat_pkg::range_res_t         range_res;

	assign in_acc    = in_valid && in_ready;
	assign is_lookup = (stat_pkg::op_t'(op) == stat_pkg::OP_LOOKUP);
	assign cfg_ready = 1'b1;

	// search limit: section_count clamped to the table size
	always_comb begin
		if (32'(count_q) > 32'(stat_pkg::SECTION_SLOTS)) begin
			limit_next = stat_pkg::LIMIT_W'(stat_pkg::SECTION_SLOTS);
		end else begin
			limit_next = stat_pkg::LIMIT_W'(count_q);
		end
	end

	// table write request; slots past the table are dropped
	assign wr_entry.base     = entry_base;
	assign wr_entry.span     = entry_span;
	assign wr_entry.file_pos = entry_file_pos;
	assign wr_en = in_acc && !is_lookup &&
		(32'(entry_index) < 32'(stat_pkg::SECTION_SLOTS));

	// read address runs one entry ahead of the entry being checked
	assign rd_addr = (state_q == stat_pkg::ST_IDLE) ? '0 : idx_q + 1'b1;

	stat_table u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (stat_pkg::SLOT_W'(entry_index)),
		.wr_data (wr_entry),
		.rd_addr (rd_addr),
		.rd_data (rd_entry)
	);

	stat_range_unit u_range (
		.rva   (rva_q),
		.entry (rd_entry),
		.res   (range_res)
	);

	assign last_entry = (stat_pkg::LIMIT_W'(idx_q) + 1'b1) == limit_q;
	assign out_load   = (state_q == stat_pkg::ST_EMIT) && (!out_valid_q || out_ready);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stat_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			stat_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (is_lookup && (limit_next != '0)) begin
						state_d = stat_pkg::ST_SCAN;
					end else begin
						state_d = stat_pkg::ST_EMIT;
					end
				end
			end
			stat_pkg::ST_SCAN: begin
				if (range_res.hit || last_entry) begin
					state_d = stat_pkg::ST_EMIT;
				end
			end
			stat_pkg::ST_EMIT: begin
				if (out_load) begin
					state_d = stat_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = stat_pkg::ST_IDLE;
			end
		endcase
	end

	// section count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			count_q <= cfg_data;
		end
	end

	// scan index, limit and hit flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			limit_q   <= '0;
			res_hit_q <= 1'b0;
		end else begin
			case (state_q)
				stat_pkg::ST_IDLE: begin
					idx_q     <= '0;
					limit_q   <= limit_next;
					res_hit_q <= 1'b0;
				end
				stat_pkg::ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (range_res.hit) begin
						res_hit_q <= 1'b1;
					end
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

	// lookup address and offset operands
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rva_q <= rva;
		end
		if ((state_q == stat_pkg::ST_SCAN) && range_res.hit) begin
			res_idx_q   <= idx_q;
			res_delta_q <= range_res.delta;
			res_pos_q   <= rd_entry.file_pos;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (res_hit_q) begin
				found_q       <= 1'b1;
				hit_index_q   <= stat_pkg::HIT_W'(res_idx_q);
				file_offset_q <= res_delta_q + res_pos_q;
			end else begin
				found_q       <= 1'b0;
				hit_index_q   <= stat_pkg::MISS_INDEX;
				file_offset_q <= stat_pkg::MISS_OFFSET;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign hit_index   = hit_index_q;
	assign file_offset = file_offset_q;

	// a hit never names a slot outside the table
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found) |-> (32'(hit_index) < 32'(stat_pkg::SECTION_SLOTS)))
		else $error("hit index outside table");

	// a miss or write result carries the all-ones index and offset
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |->
		((hit_index == stat_pkg::MISS_INDEX) && (file_offset == stat_pkg::MISS_OFFSET)))
		else $error("miss result not all ones");

	// the scan never checks an entry at or past the search limit
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == stat_pkg::ST_SCAN) |-> (stat_pkg::LIMIT_W'(idx_q) < limit_q))
		else $error("scan past search limit");

	// an accepted request always leaves the idle state
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q != stat_pkg::ST_IDLE))
		else $error("request accepted without work");

endmodule

`default_nettype wire

@@ rtl/stat_table.sv @@
`default_nettype none

module stat_table (
	input  wire                                 clk,
	input  wire                                 wr_en,
	input  wire logic [stat_pkg::SLOT_W-1:0]    wr_addr,
	input  wire stat_pkg::sect_entry_t          wr_data,
	input  wire logic [stat_pkg::SLOT_W-1:0]    rd_addr,
	output stat_pkg::sect_entry_t               rd_data
);

	stat_pkg::sect_entry_t mem [stat_pkg::SECTION_SLOTS];
	stat_pkg::sect_entry_t rd_data_q;

	// single write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ rtl/stat_range_unit.sv @@
`default_nettype none

module stat_range_unit (
	input  wire logic [stat_pkg::ADDR_W-1:0] rva,
	input  wire stat_pkg::sect_entry_t       entry,
	output stat_pkg::range_res_t             res
);

	logic [stat_pkg::ADDR_W:0] diff;

	// rva - base with borrow; in range when no borrow and the distance is below span
	always_comb begin
		diff      = {1'b0, rva} - {1'b0, entry.base};
		res.delta = diff[stat_pkg::ADDR_W-1:0];
		res.hit   = !diff[stat_pkg::ADDR_W] && (diff[stat_pkg::ADDR_W-1:0] < entry.span);
	end

endmodule

`default_nettype wire
